/* rtl/core/tchp_pkg.sv */
// shared types and constants for the tls client hello field parser
`default_nettype none

package tchp_pkg;

   // parse phases, one-hot
   typedef enum logic [17:0] {
      PH_IDLE       = 18'h00001,
      PH_RECVER     = 18'h00002,
      PH_RECLEN     = 18'h00004,
      PH_HSTYPE     = 18'h00008,
      PH_HSLEN      = 18'h00010,
      PH_HELLOVER   = 18'h00020,
      PH_GMT        = 18'h00040,
      PH_RANDOM     = 18'h00080,
      PH_SIDLEN     = 18'h00100,
      PH_SIDSKIP    = 18'h00200,
      PH_CIPHLEN    = 18'h00400,
      PH_CIPHER     = 18'h00800,
      PH_COMPCNT    = 18'h01000,
      PH_COMP       = 18'h02000,
      PH_EXTLEN     = 18'h04000,
      PH_EXTTYPE    = 18'h08000,
      PH_EXTITEMLEN = 18'h10000,
      PH_EXTSKIP    = 18'h20000
   } phase_type;

   // field kinds on the result channel
   localparam logic [3:0] KIND_RECTYPE    = 4'd0;
   localparam logic [3:0] KIND_RECVER     = 4'd1;
   localparam logic [3:0] KIND_RECLEN     = 4'd2;
   localparam logic [3:0] KIND_HSTYPE     = 4'd3;
   localparam logic [3:0] KIND_HSLEN      = 4'd4;
   localparam logic [3:0] KIND_HELLOVER   = 4'd5;
   localparam logic [3:0] KIND_GMT        = 4'd6;
   localparam logic [3:0] KIND_SIDLEN     = 4'd7;
   localparam logic [3:0] KIND_CIPHCNT    = 4'd8;
   localparam logic [3:0] KIND_CIPHER     = 4'd9;
   localparam logic [3:0] KIND_COMPCNT    = 4'd10;
   localparam logic [3:0] KIND_COMP       = 4'd11;
   localparam logic [3:0] KIND_EXTLEN     = 4'd12;
   localparam logic [3:0] KIND_EXTTYPE    = 4'd13;
   localparam logic [3:0] KIND_EXTITEMLEN = 4'd14;
   localparam logic [3:0] KIND_END        = 4'd15;

   localparam logic [15:0] RANDOM_BYTES = 16'd28;
   localparam logic [23:0] OFFSET_MAX   = 24'hFFFFFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_req;
   } item_type;

   typedef struct packed {
      logic        valid;
      logic [3:0]  field_kind;
      logic [31:0] field_value;
      logic        last;
   } result_type;

endpackage

`default_nettype wire

/* rtl/core/tchp_in_stage.sv */
// input register stage for incoming request bytes
`default_nettype none

module tchp_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire tchp_pkg::item_type req_item,
   input  wire logic              advance,
   output logic                   item_valid,
   output tchp_pkg::item_type     item
);

   logic               valid_ff;
   logic               valid_in;
   tchp_pkg::item_type item_ff;
   logic               accept;

   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

/* rtl/core/tchp_parser.sv */
// parse state and per-byte field decode
`default_nettype none

module tchp_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire tchp_pkg::item_type item,
   output tchp_pkg::result_type    res
);

   tchp_pkg::phase_type phase_ff, phase_in;
   logic [2:0]          idx_ff, idx_in;
   logic [31:0]         acc_ff, acc_in;
   logic [23:0]         off_ff, off_in;
   logic [23:0]         hlen_ff, hlen_in;
   logic [15:0]         items_ff, items_in;
   logic [15:0]         skip_ff, skip_in;

   logic [31:0] gath_acc;
   logic [2:0]  gath_idx;
   logic [2:0]  gath_need;
   logic        gath_done;
   logic        uses_gather;
   logic        counts_offset;
   logic [23:0] off_inc;
   logic        at_end;
   logic [15:0] items_dec;
   logic [15:0] skip_dec;
   logic [7:0]  b;

   assign b         = item.data_byte;
   assign gath_acc  = {acc_ff[23:0], b};
   assign gath_idx  = idx_ff + 3'd1;
   assign off_inc   = (off_ff != tchp_pkg::OFFSET_MAX) ? off_ff + 24'd1 : off_ff;
   assign at_end    = off_inc >= hlen_ff;
   assign items_dec = items_ff - 16'd1;
   assign skip_dec  = skip_ff - 16'd1;

   always_comb begin
      case (phase_ff)
         tchp_pkg::PH_HSLEN: begin
            gath_need = 3'd3;
         end
         tchp_pkg::PH_GMT: begin
            gath_need = 3'd4;
         end
         default: begin
            gath_need = 3'd2;
         end
      endcase
   end

   assign gath_done = gath_idx >= gath_need;

   assign uses_gather = phase_ff inside {tchp_pkg::PH_RECVER, tchp_pkg::PH_RECLEN,
      tchp_pkg::PH_HSLEN, tchp_pkg::PH_HELLOVER, tchp_pkg::PH_GMT, tchp_pkg::PH_CIPHLEN,
      tchp_pkg::PH_CIPHER, tchp_pkg::PH_EXTLEN, tchp_pkg::PH_EXTTYPE,
      tchp_pkg::PH_EXTITEMLEN};

   // the hello body offset runs from the hello version on
   assign counts_offset = !(phase_ff inside {tchp_pkg::PH_IDLE, tchp_pkg::PH_RECVER,
      tchp_pkg::PH_RECLEN, tchp_pkg::PH_HSTYPE, tchp_pkg::PH_HSLEN});

   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      acc_in   = acc_ff;
      off_in   = off_ff;
      hlen_in  = hlen_ff;
      items_in = items_ff;
      skip_in  = skip_ff;
      res      = '0;
      if (item.start_req) begin
         phase_in        = tchp_pkg::PH_RECVER;
         idx_in          = '0;
         acc_in          = '0;
         off_in          = '0;
         hlen_in         = '0;
         items_in        = '0;
         skip_in         = '0;
         res.valid       = 1'b1;
         res.field_kind  = tchp_pkg::KIND_RECTYPE;
         res.field_value = {24'd0, b};
      end else begin
         if (counts_offset) begin
            off_in = off_inc;
         end
         if (uses_gather) begin
            acc_in = gath_done ? 32'd0 : gath_acc;
            idx_in = gath_done ? 3'd0 : gath_idx;
         end
         case (phase_ff)
            tchp_pkg::PH_IDLE: begin
               phase_in = tchp_pkg::PH_IDLE;
            end
            tchp_pkg::PH_RECVER: begin
               if (gath_done) begin
                  phase_in        = tchp_pkg::PH_RECLEN;
                  res.valid       = 1'b1;
                  res.field_kind  = tchp_pkg::KIND_RECVER;
                  res.field_value = gath_acc;
               end
            end
            tchp_pkg::PH_RECLEN: begin
               if (gath_done) begin
                  phase_in        = tchp_pkg::PH_HSTYPE;
                  res.valid       = 1'b1;
                  res.field_kind  = tchp_pkg::KIND_RECLEN;
                  res.field_value = gath_acc;
               end
            end
            tchp_pkg::PH_HSTYPE: begin
               phase_in        = tchp_pkg::PH_HSLEN;
               res.valid       = 1'b1;
               res.field_kind  = tchp_pkg::KIND_HSTYPE;
               res.field_value = {24'd0, b};
            end
            tchp_pkg::PH_HSLEN: begin
               if (gath_done) begin
                  hlen_in         = gath_acc[23:0];
                  off_in          = '0;
                  phase_in        = tchp_pkg::PH_HELLOVER;
                  res.valid       = 1'b1;
                  res.field_kind  = tchp_pkg::KIND_HSLEN;
                  res.field_value = {8'd0, gath_acc[23:0]};
               end
            end
            tchp_pkg::PH_HELLOVER: begin
               if (gath_done) begin
                  phase_in        = tchp_pkg::PH_GMT;
                  res.valid       = 1'b1;
                  res.field_kind  = tchp_pkg::KIND_HELLOVER;
                  res.field_value = gath_acc;
               end
            end
            tchp_pkg::PH_GMT: begin
               if (gath_done) begin
                  skip_in         = tchp_pkg::RANDOM_BYTES;
                  phase_in        = tchp_pkg::PH_RANDOM;
                  res.valid       = 1'b1;
                  res.field_kind  = tchp_pkg::KIND_GMT;
                  res.field_value = gath_acc;
               end
            end
            tchp_pkg::PH_RANDOM: begin
               skip_in = skip_dec;
               if (skip_dec == 16'd0) begin
                  phase_in = tchp_pkg::PH_SIDLEN;
               end
            end
            tchp_pkg::PH_SIDLEN: begin
               if (b == 8'd0) begin
                  phase_in = tchp_pkg::PH_CIPHLEN;
               end else begin
                  skip_in  = {8'd0, b};
                  phase_in = tchp_pkg::PH_SIDSKIP;
               end
               res.valid       = 1'b1;
               res.field_kind  = tchp_pkg::KIND_SIDLEN;
               res.field_value = {24'd0, b};
            end
            tchp_pkg::PH_SIDSKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 16'd0) begin
                  phase_in = tchp_pkg::PH_CIPHLEN;
               end
            end
            tchp_pkg::PH_CIPHLEN: begin
               if (gath_done) begin
                  // two bytes per suite, an odd byte is dropped
                  items_in        = {1'b0, gath_acc[15:1]};
                  phase_in        = (gath_acc[15:1] == 15'd0) ? tchp_pkg::PH_COMPCNT
                                                              : tchp_pkg::PH_CIPHER;
                  res.valid       = 1'b1;
                  res.field_kind  = tchp_pkg::KIND_CIPHCNT;
                  res.field_value = {17'd0, gath_acc[15:1]};
               end
            end
            tchp_pkg::PH_CIPHER: begin
               if (gath_done) begin
                  items_in = items_dec;
                  if (items_dec == 16'd0) begin
                     phase_in = tchp_pkg::PH_COMPCNT;
                  end
                  res.valid       = 1'b1;
                  res.field_kind  = tchp_pkg::KIND_CIPHER;
                  res.field_value = gath_acc;
               end
            end
            tchp_pkg::PH_COMPCNT: begin
               items_in = {8'd0, b};
               if (b == 8'd0) begin
                  if (at_end) begin
                     phase_in = tchp_pkg::PH_IDLE;
                     res.last = 1'b1;
                  end else begin
                     phase_in = tchp_pkg::PH_EXTLEN;
                  end
               end else begin
                  phase_in = tchp_pkg::PH_COMP;
               end
               res.valid       = 1'b1;
               res.field_kind  = tchp_pkg::KIND_COMPCNT;
               res.field_value = {24'd0, b};
            end
            tchp_pkg::PH_COMP: begin
               items_in = items_dec;
               if (items_dec == 16'd0) begin
                  if (at_end) begin
                     phase_in = tchp_pkg::PH_IDLE;
                     res.last = 1'b1;
                  end else begin
                     phase_in = tchp_pkg::PH_EXTLEN;
                  end
               end
               res.valid       = 1'b1;
               res.field_kind  = tchp_pkg::KIND_COMP;
               res.field_value = {24'd0, b};
            end
            tchp_pkg::PH_EXTLEN: begin
               if (gath_done) begin
                  if (at_end) begin
                     phase_in = tchp_pkg::PH_IDLE;
                     res.last = 1'b1;
                  end else begin
                     phase_in = tchp_pkg::PH_EXTTYPE;
                  end
                  res.valid       = 1'b1;
                  res.field_kind  = tchp_pkg::KIND_EXTLEN;
                  res.field_value = gath_acc;
               end
            end
            tchp_pkg::PH_EXTTYPE: begin
               if (gath_done) begin
                  phase_in        = tchp_pkg::PH_EXTITEMLEN;
                  res.valid       = 1'b1;
                  res.field_kind  = tchp_pkg::KIND_EXTTYPE;
                  res.field_value = gath_acc;
               end
            end
            tchp_pkg::PH_EXTITEMLEN: begin
               if (gath_done) begin
                  if (gath_acc == 32'd0) begin
                     if (at_end) begin
                        phase_in = tchp_pkg::PH_IDLE;
                        res.last = 1'b1;
                     end else begin
                        phase_in = tchp_pkg::PH_EXTTYPE;
                     end
                  end else begin
                     skip_in  = gath_acc[15:0];
                     phase_in = tchp_pkg::PH_EXTSKIP;
                  end
                  res.valid       = 1'b1;
                  res.field_kind  = tchp_pkg::KIND_EXTITEMLEN;
                  res.field_value = gath_acc;
               end
            end
            tchp_pkg::PH_EXTSKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 16'd0) begin
                  if (at_end) begin
                     // message ends with an extension body
                     phase_in        = tchp_pkg::PH_IDLE;
                     res.valid       = 1'b1;
                     res.field_kind  = tchp_pkg::KIND_END;
                     res.field_value = '0;
                     res.last        = 1'b1;
                  end else begin
                     phase_in = tchp_pkg::PH_EXTTYPE;
                  end
               end
            end
            default: begin
               phase_in = tchp_pkg::PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tchp_pkg::PH_IDLE;
         idx_ff   <= '0;
         acc_ff   <= '0;
         off_ff   <= '0;
         hlen_ff  <= '0;
         items_ff <= '0;
         skip_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         acc_ff   <= acc_in;
         off_ff   <= off_in;
         hlen_ff  <= hlen_in;
         items_ff <= items_in;
         skip_ff  <= skip_in;
      end
   end

   // a completed message leaves the parser idle
   a_last_goes_idle: assert property (@(posedge clock) disable iff (reset)
      step && res.valid && res.last |=> phase_ff == tchp_pkg::PH_IDLE)
      else $error("parser not idle after last field");

   // field byte count never passes the widest field
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff < 3'd4)
      else $error("field byte index out of range");

   // idle bytes without a start make nothing
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == tchp_pkg::PH_IDLE && !item.start_req |-> !res.valid)
      else $error("result produced while idle");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      res.valid && res.field_kind == tchp_pkg::KIND_END |-> res.last && res.field_value == '0)
      else $error("end result without last");

endmodule

`default_nettype wire

/* rtl/core/tchp_rsp_reg.sv */
// result register driving the response channel
`default_nettype none

module tchp_rsp_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire tchp_pkg::result_type res,
   output logic                      out_free,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [3:0]                rsp_field_kind,
   output logic [31:0]               rsp_field_value,
   output logic                      rsp_last
);

   logic        valid_ff, valid_in;
   logic [3:0]  kind_ff;
   logic [31:0] value_ff;
   logic        last_ff;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      if (load) begin
         valid_in = res.valid;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && res.valid) begin
         kind_ff  <= res.field_kind;
         value_ff <= res.field_value;
         last_ff  <= res.last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_field_kind  = kind_ff;
   assign rsp_field_value = value_ff;
   assign rsp_last        = last_ff;

endmodule

`default_nettype wire

/* rtl/core/tls_client_hello_field_parser.sv */
// top level of the tls client hello field parser
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  data_byte[7:0], start_req
//   rsp_      out        rsp_valid/rsp_stall  field_kind[3:0], field_value[31:0], last
//
// one request byte per cycle sustained while rsp_stall is low; each accepted byte is
// held in the input register, then its result in the result register
// the decode between the two registers is a single pass per byte
// reset clears the parse to idle and both registers to empty
// a stalled result holds in the result register; the input register keeps
// accepting as long as the result register can take the next byte's outcome
`default_nettype none

module tls_client_hello_field_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_start_req,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_field_kind,
   output logic [31:0]      rsp_field_value,
   output logic             rsp_last
);

   tchp_pkg::item_type   req_item;
   tchp_pkg::item_type   item;
   tchp_pkg::result_type res;
   logic                 item_valid;
   logic                 out_free;
   logic                 advance;

   assign req_item.data_byte = req_data_byte;
   assign req_item.start_req = req_start_req;

   assign advance = item_valid && out_free;

   tchp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   tchp_parser u_parser (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (item),
      .res   (res)
   );

   tchp_rsp_reg u_rsp_reg (
      .clock           (clock),
      .reset           (reset),
      .load            (advance),
      .res             (res),
      .out_free        (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_field_kind  (rsp_field_kind),
      .rsp_field_value (rsp_field_value),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire
